/* hdl/cfcs_pkg.sv */
// Package for the CAN frame CRC serializer: transfer payload types, frame
// constants, the sequencer state type and the bytewise CRC16 update function.
// No dependencies.
`default_nettype none

package cfcs_pkg;

  localparam int unsigned FrameLen = 24;
  localparam int unsigned PosW = 5;

  localparam logic [PosW-1:0] PosStampLo = 5'd2;
  localparam logic [PosW-1:0] PosIdentLo = 5'd6;
  localparam logic [PosW-1:0] PosCode = 5'd10;
  localparam logic [PosW-1:0] PosPad = 5'd11;
  localparam logic [PosW-1:0] PosDataLo = 5'd12;
  localparam logic [PosW-1:0] PosCrcHi = 5'd20;
  localparam logic [PosW-1:0] PosCrcLo = 5'd21;
  localparam logic [PosW-1:0] PosFoot0 = 5'd22;
  localparam logic [PosW-1:0] PosLast = 5'(FrameLen - 1);

  localparam logic [7:0] SyncA = 8'hAA;
  localparam logic [7:0] SyncB = 8'h55;
  localparam logic [7:0] PadByte = 8'h00;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [3:0] MaxDataLen = 4'd8;

  typedef struct packed {
    logic [31:0] time_stamp;
    logic [31:0] can_id;
    logic [3:0]  length_code;
    logic [63:0] data_bytes;
  } in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } out_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_e;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hdl/can_frame_crc_serializer_core.sv */
// After a message transfer the sequencer enters the send state, and the first byte of the
// frame is then loaded into the output register. Each message is taken in the idle state,
// then its 24 frame bytes are sent; the CRC byte unit covers frame bytes 2 to 19.
// The input stalls while a frame is being sent; the output register holds each byte.
// Reset clears the sequencer, byte counter and output valid; the CRC resets to FFFF.
// Depends on cfcs_pkg.
`default_nettype none

module can_frame_crc_serializer_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire cfcs_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output cfcs_pkg::out_t     out_data_o
);
  import cfcs_pkg::*;

  state_e          state_q, state_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     crc_q, crc_d;
  in_t             msg_q;
  logic            out_valid_q, out_valid_d;
  out_t            out_q, out_d;

  logic            in_take;
  logic            load_en;
  logic [7:0]      cur_byte;
  logic [2:0]      data_idx;
  logic [63:0]     data_shift;
  logic            data_used;
  logic            in_crc_span;

  assign data_idx   = 3'(pos_q - PosDataLo);
  assign data_shift = msg_q.data_bytes >> {data_idx, 3'b000};
  assign data_used  = (msg_q.length_code != 4'd0) && (msg_q.length_code <= MaxDataLen)
                      && ({1'b0, data_idx} < msg_q.length_code);
  assign in_crc_span = (pos_q >= PosStampLo) && (pos_q < PosCrcHi);

  always_comb begin
    cur_byte = PadByte;
    if (pos_q == 5'd0) begin
      cur_byte = SyncA;
    end else if (pos_q == 5'd1) begin
      cur_byte = SyncB;
    end else if (pos_q < PosIdentLo) begin
      cur_byte = 8'(msg_q.time_stamp >> {2'(pos_q - PosStampLo), 3'b000});
    end else if (pos_q < PosCode) begin
      cur_byte = 8'(msg_q.can_id >> {2'(pos_q - PosIdentLo), 3'b000});
    end else if (pos_q == PosCode) begin
      cur_byte = {4'd0, msg_q.length_code};
    end else if (pos_q == PosPad) begin
      cur_byte = PadByte;
    end else if (pos_q < PosCrcHi) begin
      cur_byte = data_used ? data_shift[7:0] : PadByte;
    end else if (pos_q == PosCrcHi) begin
      cur_byte = crc_q[15:8];
    end else if (pos_q == PosCrcLo) begin
      cur_byte = crc_q[7:0];
    end else if (pos_q == PosFoot0) begin
      cur_byte = SyncB;
    end else begin
      cur_byte = SyncA;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SEND;
        end
      end
      ST_SEND: begin
        if (load_en && pos_q == PosLast) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    in_take    = 1'b0;
    load_en    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        in_take    = in_valid_i;
      end
      ST_SEND: begin
        load_en = !out_valid_q || !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (in_take) begin
      pos_d = '0;
      crc_d = CrcInit;
    end else if (load_en) begin
      out_valid_d      = 1'b1;
      out_d.frame_byte = cur_byte;
      out_d.frame_last = (pos_q == PosLast);
      pos_d            = (pos_q == PosLast) ? '0 : pos_q + 5'd1;
      if (in_crc_span) begin
        crc_d = crc_byte(crc_q, cur_byte);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_take) begin
      msg_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> pos_q == '0)
    else $error("byte counter not at zero while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_SEND && crc_q == CrcInit && pos_q == '0)
    else $error("frame did not start cleanly after message transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_en && pos_q == PosLast |=> state_q == ST_IDLE && out_valid_q && out_q.frame_last)
    else $error("frame end not followed by idle with last byte pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_last |-> out_data_o.frame_byte == SyncA)
    else $error("last byte of frame is not the closing footer byte");

endmodule

`default_nettype wire

/* verif/tb_can_frame_crc_serializer_core.sv */
// Self-checking testbench for can_frame_crc_serializer_core: directed and random CAN messages,
// each 24-byte frame checked byte by byte against a local frame and CRC16 predictor.
// Depends on cfcs_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_can_frame_crc_serializer_core;
  import cfcs_pkg::*;

  typedef struct packed {
    in_t         msg;
    logic        typed;
    logic [63:0] data_exp;
  } vector_t;

  localparam int unsigned NumDirected = 18;
  localparam int unsigned NumRandom = 212;
  localparam int unsigned MaxPrinted = 200;

  logic clk;
  logic rst_n;
  logic msg_valid;
  logic msg_stall;
  in_t  msg_data;
  logic byte_valid;
  logic byte_stall;
  out_t byte_data;

  out_t        frame_q[$];
  int unsigned error_count;
  bit          quiet_phase;
  bit          typed_payload;
  logic [63:0] typed_data;

  can_frame_crc_serializer_core i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (msg_valid),
    .in_stall_o (msg_stall),
    .in_data_i  (msg_data),
    .out_valid_o(byte_valid),
    .out_stall_i(byte_stall),
    .out_data_o (byte_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = crc[15] ^ b[i];
      crc = {crc[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return crc;
  endfunction

  function automatic logic [63:0] used_data(in_t m);
    logic [63:0] d;
    d = '0;
    if (m.length_code >= 4'd1 && m.length_code <= MaxDataLen) begin
      for (int i = 0; i < 8; i++) begin
        if (i < m.length_code) begin
          d[8*i +: 8] = m.data_bytes[8*i +: 8];
        end
      end
    end
    return d;
  endfunction

  function automatic int unsigned draw_wait();
    if (quiet_phase || $urandom_range(0, 2) != 0) begin
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  task automatic queue_frame(in_t m, logic [63:0] data);
    logic [7:0]  bytes [FrameLen];
    logic [15:0] crc;
    out_t        o;
    bytes[0] = SyncA;
    bytes[1] = SyncB;
    for (int i = 0; i < 4; i++) begin
      bytes[PosStampLo + i] = m.time_stamp[8*i +: 8];
      bytes[PosIdentLo + i] = m.can_id[8*i +: 8];
    end
    bytes[PosCode] = {4'h0, m.length_code};
    bytes[PosPad] = PadByte;
    for (int i = 0; i < 8; i++) begin
      bytes[PosDataLo + i] = data[8*i +: 8];
    end
    crc = CrcInit;
    for (int i = PosStampLo; i < PosCrcHi; i++) begin
      crc = crc16_step(crc, bytes[i]);
    end
    bytes[PosCrcHi] = crc[15:8];
    bytes[PosCrcLo] = crc[7:0];
    bytes[PosFoot0] = SyncB;
    bytes[PosLast] = SyncA;
    for (int i = 0; i < FrameLen; i++) begin
      o.frame_byte = bytes[i];
      o.frame_last = (i == PosLast);
      frame_q.push_back(o);
    end
  endtask

  task automatic note_mismatch(string what);
    error_count++;
    if (error_count <= MaxPrinted) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
  endtask

  task automatic send_message(in_t m, logic typed, logic [63:0] data_exp);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      msg_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    msg_valid = 1'b1;
    msg_data = m;
    typed_payload = typed;
    typed_data = data_exp;
    do @(posedge clk); while (msg_stall);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : frame_checker
    out_t want;
    if (rst_n && msg_valid && !msg_stall) begin
      queue_frame(msg_data, typed_payload ? typed_data : used_data(msg_data));
    end
    if (rst_n && byte_valid && !byte_stall) begin
      if (frame_q.size() == 0) begin
        note_mismatch($sformatf("byte %02h with no frame pending", byte_data.frame_byte));
      end else begin
        want = frame_q.pop_front();
        if (byte_data.frame_byte !== want.frame_byte) begin
          note_mismatch($sformatf("frame_byte %02h, wanted %02h",
                                  byte_data.frame_byte, want.frame_byte));
        end
        if (byte_data.frame_last !== want.frame_last) begin
          note_mismatch($sformatf("frame_last %b, wanted %b",
                                  byte_data.frame_last, want.frame_last));
        end
      end
    end
  end

  initial begin : receiver
    int unsigned hold;
    int unsigned seen;
    bit          held_off;
    byte_stall = 1'b0;
    seen = 0;
    held_off = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      hold = draw_wait();
      if (!held_off && seen >= 500) begin
        hold = 300;
        held_off = 1'b1;
      end
      if (hold > 0) begin
        byte_stall = 1'b1;
        repeat (hold) @(negedge clk);
        byte_stall = 1'b0;
      end
      do @(posedge clk); while (!byte_valid);
      seen++;
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    vector_t directed [NumDirected];
    in_t     m;
    rst_n = 1'b0;
    msg_valid = 1'b0;
    msg_data = '0;
    typed_payload = 1'b0;
    typed_data = '0;
    quiet_phase = 1'b0;
    error_count = 0;

    directed[0]  = {32'h0000_0000, 32'h0000_0000, 4'h0, 64'h0000_0000_0000_0000,
                    1'b1, 64'h0000_0000_0000_0000};
    directed[1]  = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF,
                    1'b1, 64'h0000_0000_0000_0000};
    directed[2]  = {32'h0000_0000, 32'h0000_0000, 4'h8, 64'hFFFF_FFFF_FFFF_FFFF,
                    1'b1, 64'hFFFF_FFFF_FFFF_FFFF};
    directed[3]  = {32'h1234_5678, 32'h9ABC_DEF0, 4'h1, 64'h8877_6655_4433_2211,
                    1'b1, 64'h0000_0000_0000_0011};
    directed[4]  = {32'h1234_5678, 32'h9ABC_DEF0, 4'h2, 64'h8877_6655_4433_2211,
                    1'b1, 64'h0000_0000_0000_2211};
    directed[5]  = {32'h1234_5678, 32'h9ABC_DEF0, 4'h3, 64'h8877_6655_4433_2211,
                    1'b1, 64'h0000_0000_0033_2211};
    directed[6]  = {32'h1234_5678, 32'h9ABC_DEF0, 4'h4, 64'h8877_6655_4433_2211,
                    1'b1, 64'h0000_0000_4433_2211};
    directed[7]  = {32'h1234_5678, 32'h9ABC_DEF0, 4'h5, 64'h8877_6655_4433_2211,
                    1'b1, 64'h0000_0055_4433_2211};
    directed[8]  = {32'h1234_5678, 32'h9ABC_DEF0, 4'h6, 64'h8877_6655_4433_2211,
                    1'b1, 64'h0000_6655_4433_2211};
    directed[9]  = {32'h1234_5678, 32'h9ABC_DEF0, 4'h7, 64'h8877_6655_4433_2211,
                    1'b1, 64'h0077_6655_4433_2211};
    directed[10] = {32'h1234_5678, 32'h9ABC_DEF0, 4'h8, 64'h8877_6655_4433_2211,
                    1'b1, 64'h8877_6655_4433_2211};
    directed[11] = {32'h0000_0001, 32'h0000_07FF, 4'h9, 64'hFFFF_FFFF_FFFF_FFFF,
                    1'b1, 64'h0000_0000_0000_0000};
    directed[12] = {32'h8000_0000, 32'h1FFF_FFFF, 4'hC, 64'h0123_4567_89AB_CDEF,
                    1'b1, 64'h0000_0000_0000_0000};
    directed[13] = {32'hFFFF_FFFF, 32'h0000_0000, 4'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                    1'b1, 64'h0000_0000_0000_0000};
    directed[14] = {32'h0000_0000, 32'hFFFF_FFFF, 4'h8, 64'h0000_0000_0000_0000,
                    1'b1, 64'h0000_0000_0000_0000};
    directed[15] = {32'hAAAA_AAAA, 32'h5555_5555, 4'h5, 64'hAAAA_AAAA_AAAA_AAAA,
                    1'b0, 64'h0};
    directed[16] = {32'h5555_5555, 32'hAAAA_AAAA, 4'hA, 64'h5555_5555_5555_5555,
                    1'b0, 64'h0};
    directed[17] = {32'h8000_0001, 32'h0000_0001, 4'h8, 64'h8000_0000_0000_0001,
                    1'b0, 64'h0};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < NumDirected; i++) begin
      send_message(directed[i].msg, directed[i].typed, directed[i].data_exp);
    end
    for (int n = 0; n < NumRandom; n++) begin
      quiet_phase = (n >= 80 && n < 120);
      m = {$urandom, $urandom, 4'($urandom_range(0, 15)), $urandom, $urandom};
      send_message(m, 1'b0, 64'h0);
    end
    msg_valid = 1'b0;

    while (frame_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/cfcs_pkg.sv
hdl/can_frame_crc_serializer_core.sv
verif/tb_can_frame_crc_serializer_core.sv
